@@ hdl/ysc_pkg.sv @@
// Shared types and fixed-point constants for the YCbCr elliptical skin classifier.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package ysc_pkg;

  // Register stages from input capture to the output register
  localparam int NumStages = 10;

  // One bit per stage: load enable / valid flags
  typedef logic [NumStages-1:0] stage_vec_t;

  // Luma band where chroma passes unchanged, and clamp limits for correction
  localparam int LumaKl   = 125;
  localparam int LumaKh   = 188;
  localparam int LumaMin  = 16;
  localparam int LumaMax  = 235;

  // Cluster centres at the upper band edge (integer chroma)
  localparam int KcBlue   = 108;
  localparam int KcRed    = 154;

  // Cluster width constants, in hundredths
  localparam int W0Blue   = 4697;
  localparam int W0Red    = 3876;
  localparam int BaseBlueLo  = 2300;
  localparam int SlopeBlueLo = 2397;
  localparam int BaseBlueHi  = 1400;
  localparam int SlopeBlueHi = 3297;
  localparam int BaseRedLo   = 2000;
  localparam int SlopeRedLo  = 1876;
  localparam int BaseRedHi   = 1000;
  localparam int SlopeRedHi  = 2876;

  // Centre drift across each outer band (chroma units)
  localparam int DriftBlue   = 10;
  localparam int DriftRedLo  = 10;
  localparam int DriftRedHi  = 22;

  // Unity scale in Q2.14
  localparam int ScaleOneQ14 = 16384;

  // Band-edge centres in Q8 added back after scaling
  localparam logic signed [34:0] KcBlueQ8 = 35'sd27648;
  localparam logic signed [34:0] KcRedQ8  = 35'sd39424;

  // Signed Q9.8 saturation limits
  localparam logic signed [34:0] Q98Max   = 35'sd131071;
  localparam logic signed [34:0] Q98Min   = -35'sd131072;

  // Ellipse centre and offset in Q8
  localparam logic signed [18:0] EllCxQ8  = 19'sd28001;
  localparam logic signed [18:0] EllCyQ8  = 19'sd38917;
  localparam logic signed [19:0] EllOxQ8  = 20'sd410;
  localparam logic signed [19:0] EllOyQ8  = 20'sd617;

  // Rotation and inverse semi-axes in Q2.14
  localparam logic signed [15:0] CosQ14   = -16'sd13414;
  localparam logic signed [15:0] SinQ14   = 16'sd9407;
  localparam logic signed [12:0] InvAQ14  = 13'sd645;
  localparam logic signed [12:0] InvBQ14  = 13'sd1168;

  // Half LSB for round-half-up on a 14-bit shift
  localparam int RoundQ14 = 8192;

  // 1.0 in Q4.16
  localparam logic signed [36:0] OneQ16   = 37'sd65536;

endpackage

`default_nettype wire

@@ hdl/ysc_pipe_ctrl.sv @@
// Valid bits and per-stage ready chain for the classifier pipeline.
// Depends on ysc_pkg for the stage count and stage vector type.
`default_nettype none

module ysc_pipe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ysc_pkg::stage_vec_t    load_o
);

  localparam int Ns = ysc_pkg::NumStages;

  ysc_pkg::stage_vec_t valid_q, valid_d;
  logic [Ns:0]         ready;

  // A stage may load when it is empty or its contents move on this cycle
  always_comb begin
    ready[Ns] = out_ready_i;
    for (int k = Ns - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < Ns; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign load_o      = ready[Ns-1:0];
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[Ns-1];

  // Input side only stalls when every stage holds an item and the output is held
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q) && !out_ready_i)
    else $error("input stalled with a bubble in the pipeline");

  // An accepted transfer lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted transfer lost at pipeline entry");

  // A taken result is replaced by the item behind it
  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[Ns-1] && out_ready_i && valid_q[Ns-2] |=> valid_q[Ns-1])
    else $error("item dropped between last two stages");

endmodule

`default_nettype wire

@@ hdl/ysc_chroma_corr.sv @@
// Luma-dependent chroma cluster correction: table lookup, scaling, saturation,
// and ellipse-centre shift. Stages 0..3. Depends on ysc_pkg.
`default_nettype none

module ysc_chroma_corr (
  input  wire logic                clk_i,
  input  wire ysc_pkg::stage_vec_t load_i,
  input  wire logic [7:0]          luma_i,
  input  wire logic [7:0]          blue_chroma_i,
  input  wire logic [7:0]          red_chroma_i,
  output logic signed [18:0]       db_o,
  output logic signed [18:0]       dr_o
);

  // Per-luma centre (Q8) and scale (Q2.14), worked out at elaboration.
  // Inside the pass band the scale is unity and the centre is the band-edge centre,
  // which leaves the chroma unchanged.
  logic [15:0] cen_b_tab [256];
  logic [15:0] cen_r_tab [256];
  logic [15:0] scl_b_tab [256];
  logic [15:0] scl_r_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_tab
    localparam longint YC  = (g < ysc_pkg::LumaMin) ? ysc_pkg::LumaMin :
                             ((g > ysc_pkg::LumaMax) ? ysc_pkg::LumaMax : g);
    localparam bit     MID = (g >= ysc_pkg::LumaKl) && (g <= ysc_pkg::LumaKh);
    localparam bit     LO  = YC < ysc_pkg::LumaKl;
    localparam longint DEN = LO ? (ysc_pkg::LumaKl - ysc_pkg::LumaMin)
                                : (ysc_pkg::LumaMax - ysc_pkg::LumaKh);
    localparam longint N   = LO ? (YC - ysc_pkg::LumaMin) : (ysc_pkg::LumaMax - YC);
    localparam longint D   = LO ? (ysc_pkg::LumaKl - YC) : (YC - ysc_pkg::LumaKh);
    localparam longint OFB = (D * ysc_pkg::DriftBlue * 512 + DEN) / (2 * DEN);
    localparam longint OFR = LO ? (D * ysc_pkg::DriftRedLo * 512 + DEN) / (2 * DEN)
                                : (D * ysc_pkg::DriftRedHi * 512 + DEN) / (2 * DEN);
    localparam longint KB  = ysc_pkg::KcBlue * 256;
    localparam longint KR  = ysc_pkg::KcRed * 256;
    localparam longint CB  = MID ? KB : (KB + OFB);
    localparam longint CR  = MID ? KR : (LO ? (KR - OFR) : (KR + OFR));
    localparam longint SPB = (LO ? ysc_pkg::BaseBlueLo : ysc_pkg::BaseBlueHi) * DEN
                           + N * (LO ? ysc_pkg::SlopeBlueLo : ysc_pkg::SlopeBlueHi);
    localparam longint SPR = (LO ? ysc_pkg::BaseRedLo : ysc_pkg::BaseRedHi) * DEN
                           + N * (LO ? ysc_pkg::SlopeRedLo : ysc_pkg::SlopeRedHi);
    localparam longint SB  = MID ? ysc_pkg::ScaleOneQ14 :
      (longint'(ysc_pkg::W0Blue) * 16384 * DEN * 2 + SPB) / (2 * SPB);
    localparam longint SR  = MID ? ysc_pkg::ScaleOneQ14 :
      (longint'(ysc_pkg::W0Red) * 16384 * DEN * 2 + SPR) / (2 * SPR);

    assign cen_b_tab[g] = 16'(CB);
    assign cen_r_tab[g] = 16'(CR);
    assign scl_b_tab[g] = 16'(SB);
    assign scl_r_tab[g] = 16'(SR);
  end

  // Stage 0: capture the pixel
  logic [7:0] luma_q, cb_q, cr_q;

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      luma_q <= luma_i;
      cb_q   <= blue_chroma_i;
      cr_q   <= red_chroma_i;
    end
  end

  // Stage 1: chroma minus luma-dependent centre, with scale
  logic signed [17:0] diff_b_d, diff_r_d, diff_b_q, diff_r_q;
  logic [15:0]        scl_b_q, scl_r_q;

  assign diff_b_d = $signed({2'b00, cb_q, 8'h00}) - $signed({2'b00, cen_b_tab[luma_q]});
  assign diff_r_d = $signed({2'b00, cr_q, 8'h00}) - $signed({2'b00, cen_r_tab[luma_q]});

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      diff_b_q <= diff_b_d;
      diff_r_q <= diff_r_d;
      scl_b_q  <= scl_b_tab[luma_q];
      scl_r_q  <= scl_r_tab[luma_q];
    end
  end

  // Stage 2: scale product
  logic signed [34:0] prod_b_d, prod_r_d, prod_b_q, prod_r_q;

  assign prod_b_d = diff_b_q * $signed({1'b0, scl_b_q});
  assign prod_r_d = diff_r_q * $signed({1'b0, scl_r_q});

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      prod_b_q <= prod_b_d;
      prod_r_q <= prod_r_d;
    end
  end

  // Stage 3: round, re-base, saturate to Q9.8, shift by ellipse centre
  logic signed [34:0] t_b, t_r;
  logic signed [17:0] sat_b, sat_r;
  logic signed [18:0] db_d, dr_d, db_q, dr_q;

  always_comb begin
    t_b = ((prod_b_q + 35'(ysc_pkg::RoundQ14)) >>> 14) + ysc_pkg::KcBlueQ8;
    t_r = ((prod_r_q + 35'(ysc_pkg::RoundQ14)) >>> 14) + ysc_pkg::KcRedQ8;

    if (t_b > ysc_pkg::Q98Max) begin
      sat_b = ysc_pkg::Q98Max[17:0];
    end else if (t_b < ysc_pkg::Q98Min) begin
      sat_b = ysc_pkg::Q98Min[17:0];
    end else begin
      sat_b = t_b[17:0];
    end

    if (t_r > ysc_pkg::Q98Max) begin
      sat_r = ysc_pkg::Q98Max[17:0];
    end else if (t_r < ysc_pkg::Q98Min) begin
      sat_r = ysc_pkg::Q98Min[17:0];
    end else begin
      sat_r = t_r[17:0];
    end

    db_d = 19'(sat_b) - ysc_pkg::EllCxQ8;
    dr_d = 19'(sat_r) - ysc_pkg::EllCyQ8;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[3]) begin
      db_q <= db_d;
      dr_q <= dr_d;
    end
  end

  assign db_o = db_q;
  assign dr_o = dr_q;

endmodule

`default_nettype wire

@@ hdl/ysc_ellipse_test.sv @@
// Rotation, offset, axis normalization and inside-ellipse test. Stages 4..9.
// Depends on ysc_pkg.
`default_nettype none

module ysc_ellipse_test (
  input  wire logic                clk_i,
  input  wire ysc_pkg::stage_vec_t load_i,
  input  wire logic signed [18:0]  db_i,
  input  wire logic signed [18:0]  dr_i,
  output logic                     is_skin_o
);

  // Stage 4: rotation products
  logic signed [34:0] p_bc_d, p_rs_d, p_rc_d, p_bs_d;
  logic signed [34:0] p_bc_q, p_rs_q, p_rc_q, p_bs_q;

  assign p_bc_d = db_i * ysc_pkg::CosQ14;
  assign p_rs_d = dr_i * ysc_pkg::SinQ14;
  assign p_rc_d = dr_i * ysc_pkg::CosQ14;
  assign p_bs_d = db_i * ysc_pkg::SinQ14;

  always_ff @(posedge clk_i) begin
    if (load_i[4]) begin
      p_bc_q <= p_bc_d;
      p_rs_q <= p_rs_d;
      p_rc_q <= p_rc_d;
      p_bs_q <= p_bs_d;
    end
  end

  // Stage 5: sum, round, subtract offset
  logic signed [35:0] xs, ys;
  logic signed [19:0] x_d, y_d, x_q, y_q;

  always_comb begin
    xs  = 36'(p_bc_q) + 36'(p_rs_q);
    ys  = 36'(p_rc_q) - 36'(p_bs_q);
    x_d = 20'((xs + 36'(ysc_pkg::RoundQ14)) >>> 14) - ysc_pkg::EllOxQ8;
    y_d = 20'((ys + 36'(ysc_pkg::RoundQ14)) >>> 14) - ysc_pkg::EllOyQ8;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[5]) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // Stage 6: multiply by inverse semi-axes
  logic signed [32:0] pu_d, pv_d, pu_q, pv_q;

  assign pu_d = x_q * ysc_pkg::InvAQ14;
  assign pv_d = y_q * ysc_pkg::InvBQ14;

  always_ff @(posedge clk_i) begin
    if (load_i[6]) begin
      pu_q <= pu_d;
      pv_q <= pv_d;
    end
  end

  // Stage 7: round normalized coordinates back to Q8
  logic signed [17:0] u_d, v_d, u_q, v_q;

  assign u_d = 18'((pu_q + 33'(ysc_pkg::RoundQ14)) >>> 14);
  assign v_d = 18'((pv_q + 33'(ysc_pkg::RoundQ14)) >>> 14);

  always_ff @(posedge clk_i) begin
    if (load_i[7]) begin
      u_q <= u_d;
      v_q <= v_d;
    end
  end

  // Stage 8: squares
  logic signed [35:0] uu_d, vv_d, uu_q, vv_q;

  assign uu_d = u_q * u_q;
  assign vv_d = v_q * v_q;

  always_ff @(posedge clk_i) begin
    if (load_i[8]) begin
      uu_q <= uu_d;
      vv_q <= vv_d;
    end
  end

  // Stage 9: compare full sum against 1.0
  logic signed [36:0] sum;
  logic               skin_d, skin_q;

  assign sum    = 37'(uu_q) + 37'(vv_q);
  assign skin_d = sum <= ysc_pkg::OneQ16;

  always_ff @(posedge clk_i) begin
    if (load_i[9]) begin
      skin_q <= skin_d;
    end
  end

  assign is_skin_o = skin_q;

endmodule

`default_nettype wire

@@ hdl/ycbcr_ellipse_skin_classifier.sv @@
// Top level of the YCbCr elliptical skin-color classifier: one pixel in, one flag out.
// Instantiates ysc_pipe_ctrl, ysc_chroma_corr and ysc_ellipse_test; uses ysc_pkg.
//
// Classifies each YCbCr pixel as skin or not, following the elliptical skin-color
// model with luma-dependent chroma correction outside the 125..188 luma band. The
// block is a 10-stage pipeline, and a pixel is taken on every clock unless the pipeline
// is full and the output is held. Throughput is one pixel per clock, set by the
// per-stage ready chain; holding m_axis_tready_i low fills the pipeline, after which
// s_axis_tready_o drops until a result is taken. The result outputs are registered;
// the only handshake path, combinational from m_axis_tready_i to s_axis_tready_o, is
// the ready chain through the ten stages.
`default_nettype none

module ycbcr_ellipse_skin_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input pixel
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // [7:0] luma, [15:8] blue_chroma, [23:16] red_chroma
  // Result
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o    // [0] is_skin, [7:1] zero
);

  ysc_pkg::stage_vec_t load;
  logic signed [18:0]  db, dr;
  logic                is_skin;

  // Valid tracking and stage enables
  ysc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .load_o      (load)
  );

  // Chroma correction and centre shift
  ysc_chroma_corr u_corr (
    .clk_i         (clk_i),
    .load_i        (load),
    .luma_i        (s_axis_tdata_i[7:0]),
    .blue_chroma_i (s_axis_tdata_i[15:8]),
    .red_chroma_i  (s_axis_tdata_i[23:16]),
    .db_o          (db),
    .dr_o          (dr)
  );

  // Rotation and ellipse test
  ysc_ellipse_test u_ell (
    .clk_i     (clk_i),
    .load_i    (load),
    .db_i      (db),
    .dr_i      (dr),
    .is_skin_o (is_skin)
  );

  assign m_axis_tdata_o = {7'b0000000, is_skin};

endmodule

`default_nettype wire

@@ tb/ysc_skin_checker.sv @@
// Checker for the YCbCr elliptical skin classifier: watches both stream channels,
// predicts the skin flag of every accepted pixel in fixed point and compares results.
// Depends on nothing but the port widths of ycbcr_ellipse_skin_classifier.
`default_nettype none

module ysc_skin_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [23:0] s_tdata_i,   // [7:0] luma, [15:8] blue_chroma, [23:16] red_chroma
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [7:0]  m_tdata_i,   // [0] is_skin, [7:1] zero
  output int               pending_o,
  output int               fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Luma band and clamp limits
  localparam int BandLo = 125;
  localparam int BandHi = 188;
  localparam int ClampLo = 16;
  localparam int ClampHi = 235;

  // Signed Q9.8 range of corrected chroma
  localparam longint ChromaMax = 131071;
  localparam longint ChromaMin = -131072;

  // Ellipse geometry: centre and offset in Q8, trig and inverse axes in Q2.14
  localparam longint CentreCb = 28001;
  localparam longint CentreCr = 38917;
  localparam longint OffsetX = 410;
  localparam longint OffsetY = 617;
  localparam longint CosRot = -13414;
  localparam longint SinRot = 9407;
  localparam longint InvAxisA = 645;
  localparam longint InvAxisB = 1168;
  localparam longint UnitQ16 = 65536;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       is_skin;
  } skin_flag_t;

  skin_flag_t skin_flags_q[$];

  initial begin
    pending_o = 0;
    fail_count_o = 0;
  end

  // Round half up on a right shift; arithmetic shift floors for negatives
  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Luma-dependent cluster correction of one chroma value, signed Q9.8
  function automatic longint corrected_chroma(int y_in, int c, bit red);
    int     y;
    longint centre, band_centre, w0, base, slope, den, n, sp, scale, off, t;
    if (y_in >= BandLo && y_in <= BandHi) begin
      return longint'(c) * 256;
    end
    y = (y_in < ClampLo) ? ClampLo : ((y_in > ClampHi) ? ClampHi : y_in);
    band_centre = red ? 154 : 108;
    w0 = red ? 3876 : 4697;
    if (y < BandLo) begin
      den = BandLo - ClampLo;
      n = y - ClampLo;
      off = (longint'(BandLo - y) * 10 * 512 + den) / (2 * den);
      centre = red ? (154 * 256 - off) : (108 * 256 + off);
      base = red ? 2000 : 2300;
      slope = red ? 1876 : 2397;
    end else begin
      den = ClampHi - BandHi;
      n = ClampHi - y;
      off = (longint'(y - BandHi) * (red ? 22 : 10) * 512 + den) / (2 * den);
      centre = band_centre * 256 + off;
      base = red ? 1000 : 1400;
      slope = red ? 2876 : 3297;
    end
    // spread in hundredths, times den; scale is Q2.14
    sp = base * den + n * slope;
    scale = (w0 * 16384 * den * 2 + sp) / (2 * sp);
    t = round_shr((longint'(c) * 256 - centre) * scale, 14) + band_centre * 256;
    if (t > ChromaMax) t = ChromaMax;
    if (t < ChromaMin) t = ChromaMin;
    return t;
  endfunction

  // Rotate, offset and normalize; inside or on the ellipse counts as skin
  function automatic logic predict_skin(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    longint db, dr, x, yr, u, v;
    db = corrected_chroma(int'(y), int'(cb), 1'b0) - CentreCb;
    dr = corrected_chroma(int'(y), int'(cr), 1'b1) - CentreCr;
    x = round_shr(CosRot * db + SinRot * dr, 14) - OffsetX;
    yr = round_shr(CosRot * dr - SinRot * db, 14) - OffsetY;
    u = round_shr(x * InvAxisA, 14);
    v = round_shr(yr * InvAxisB, 14);
    return (u * u + v * v <= UnitQ16);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o = fail_count_o + 1;
  endtask

  // Results are retired before new pixels are queued; the pipeline never
  // returns a pixel in its own transfer cycle
  always @(posedge clk_i) begin
    skin_flag_t exp_flag;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (skin_flags_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with no pixel pending", m_tdata_i));
        end else begin
          exp_flag = skin_flags_q.pop_front();
          if (m_tdata_i !== {7'd0, exp_flag.is_skin}) begin
            report_mismatch($sformatf("Y=%0d Cb=%0d Cr=%0d: got 0x%02h, want is_skin=%0d",
                                      exp_flag.luma, exp_flag.cb, exp_flag.cr,
                                      m_tdata_i, exp_flag.is_skin));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        exp_flag.luma = s_tdata_i[7:0];
        exp_flag.cb = s_tdata_i[15:8];
        exp_flag.cr = s_tdata_i[23:16];
        exp_flag.is_skin = predict_skin(exp_flag.luma, exp_flag.cb, exp_flag.cr);
        skin_flags_q.push_back(exp_flag);
      end
    end
    pending_o <= skin_flags_q.size();
  end

endmodule

`default_nettype wire

@@ tb/ycbcr_ellipse_skin_classifier_tb.sv @@
// Testbench top for ycbcr_ellipse_skin_classifier: drives pixels and output stalls,
// runs the watchdog and prints the verdict. Depends on ysc_skin_checker and the RTL.
`default_nettype none

module ycbcr_ellipse_skin_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomPixels = 450;
  localparam int PhaseLen = 50;
  localparam int MaxWait = 18;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 16;

  // Directed pixels, packed {cr, cb, y}: band edges, clamp edges, field extremes,
  // saturating corners and points near the ellipse centre
  localparam logic [23:0] DirectedPixels [25] = '{
    {8'd0,   8'd0,   8'd0},   {8'd255, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd0},
    {8'd0,   8'd0,   8'd255}, {8'd128, 8'd128, 8'd15},  {8'd152, 8'd109, 8'd16},
    {8'd152, 8'd109, 8'd124}, {8'd152, 8'd109, 8'd125}, {8'd152, 8'd109, 8'd188},
    {8'd152, 8'd109, 8'd189}, {8'd152, 8'd109, 8'd235}, {8'd152, 8'd109, 8'd236},
    {8'd152, 8'd109, 8'd150}, {8'd255, 8'd0,   8'd150}, {8'd0,   8'd255, 8'd150},
    {8'd150, 8'd120, 8'd170}, {8'd160, 8'd100, 8'd100}, {8'd150, 8'd110, 8'd60},
    {8'd160, 8'd110, 8'd210}, {8'd0,   8'd255, 8'd255}, {8'd255, 8'd0,   8'd255},
    {8'd255, 8'd0,   8'd0},   {8'd0,   8'd255, 8'd0},   {8'd170, 8'd85,  8'd130},
    {8'd165, 8'd115, 8'd200}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  int  pending;
  int  fail_count;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  ycbcr_ellipse_skin_classifier dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  ysc_skin_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: after each transfer draw a random stall bounded by MaxWait, unless bursting
  always @(posedge clk) begin
    int unsigned stall;
    if (rst_n) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (!m_tready) begin
        m_tready <= 1'b1;
      end else if (m_tvalid) begin
        stall = rx_burst ? 0 : $urandom_range(0, MaxWait);
        if (stall != 0) begin
          m_tready <= 1'b0;
          stall_left <= stall - 1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // One pixel transfer, preceded by a random gap unless bursting
  task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {cr, cb, y};
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    logic [7:0] y, cb, cr;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedPixels[i]) begin
      send_pixel(DirectedPixels[i][7:0], DirectedPixels[i][15:8], DirectedPixels[i][23:16]);
    end

    // Random pixels; half aimed around the skin cluster so both flag values show up
    for (int i = 0; i < RandomPixels; i++) begin
      if (i % PhaseLen == 0) begin
        case (i / PhaseLen)
          1: begin
            tx_burst = 1'b1;
            rx_burst <= 1'b1;
          end
          2: begin
            tx_burst = 1'b0;
            rx_burst <= 1'b0;
          end
          default: begin
            tx_burst = $urandom_range(0, 1);
            rx_burst <= $urandom_range(0, 1);
          end
        endcase
      end
      y = $urandom_range(0, 255);
      if ($urandom_range(0, 1) == 0) begin
        cb = $urandom_range(80, 135);
        cr = $urandom_range(130, 180);
      end else begin
        cb = $urandom_range(0, 255);
        cr = $urandom_range(0, 255);
      end
      send_pixel(y, cb, cr);
    end
    s_tvalid <= 1'b0;
    rx_burst <= 1'b0;

    // Drain: every expected flag back, then wait DrainCycles more
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/ysc_pkg.sv
hdl/ysc_pipe_ctrl.sv
hdl/ysc_chroma_corr.sv
hdl/ysc_ellipse_test.sv
hdl/ycbcr_ellipse_skin_classifier.sv
tb/ysc_skin_checker.sv
tb/ycbcr_ellipse_skin_classifier_tb.sv
